/* rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Beat structs for both channels, command codes and default sizes.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned DEFAULT_DEPTH    = 128;
  localparam logic [7:0]  DEFAULT_CAPACITY = 8'd80;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] removed_value;
    logic [7:0]         count;
    logic               is_empty;
    logic               is_full;
  } out_t;

endpackage

/* rtl/pal_ram.sv */
// ----------------------------------------------------------------------------
// pal_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/positional_array_list.sv */
// ----------------------------------------------------------------------------
// positional_array_list: ordered list with insert/delete at a 1-based position
// Sequencing: a rejected beat goes straight to the result state; an accepted
//   insert or delete first runs the shift loop, which moves one entry per
//   cycle through the single read and single write port of the store.
// Throughput: one beat at a time; in_ready_o is high only while idle.
// Reset: count clears, capacity returns to 80, store contents are left as is.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int unsigned DEPTH = pal_pkg::DEFAULT_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pal_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pal_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  import pal_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_DEL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  cap_q;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  // working registers of the shift loop
  logic [7:0]  j_q, j_d;       // next index to read (delete) or fill (insert)
  logic [7:0]  pos0_q, pos0_d; // zero-based target position
  logic [7:0]  tgt_q, tgt_d;   // write target of the read in flight
  logic        pend_q, pend_d; // a read was issued last cycle
  logic        first_q, first_d; // in-flight read is the removed entry
  logic        ok_q, ok_d;
  logic signed [31:0] val_q, val_d;
  logic signed [31:0] rem_q, rem_d;

  // store port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  // effective capacity: zero means the default, clip to the store depth
  logic [7:0] cap_raw, cap_eff;
  always_comb begin
    cap_raw = (cap_q == 8'd0) ? DEFAULT_CAPACITY : cap_q;
    cap_eff = (int'(cap_raw) > DEPTH) ? 8'(DEPTH) : cap_raw;
  end

  // acceptance checks on the incoming beat
  logic [8:0] pos_ext, cnt_ext;
  logic       ins_ok, del_ok;
  always_comb begin
    pos_ext = {1'b0, in_data_i.position};
    cnt_ext = {1'b0, cnt_q};
    ins_ok  = (in_data_i.position != 8'd0) && (pos_ext <= cnt_ext + 9'd1) &&
              (cnt_q < cap_eff);
    del_ok  = (in_data_i.position != 8'd0) && (pos_ext <= cnt_ext);
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    pos0_d      = pos0_q;
    tgt_d       = tgt_q;
    pend_d      = pend_q;
    first_d     = first_q;
    ok_d        = ok_q;
    val_d       = val_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = AW'(tgt_q);
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = AW'(j_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pos0_d  = in_data_i.position - 8'd1;
          val_d   = in_data_i.value;
          rem_d   = '0;
          pend_d  = 1'b0;
          first_d = 1'b0;
          ok_d    = 1'b0;
          if (in_data_i.command == CMD_INSERT && ins_ok) begin
            j_d     = cnt_q;
            state_d = ST_INS;
          end else if (in_data_i.command == CMD_DELETE && del_ok) begin
            j_d     = in_data_i.position - 8'd1;
            first_d = 1'b1;
            state_d = ST_DEL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      // move entries up from the tail: read j-1, write j next cycle
      ST_INS: begin
        if (pend_q) begin
          ram_we = 1'b1;
        end else if (j_q == pos0_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pos0_q);
          ram_wdata = val_q;
          cnt_d     = cnt_q + 8'd1;
          ok_d      = 1'b1;
          state_d   = ST_FIN;
        end
        if (j_q != pos0_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(j_q - 8'd1);
          tgt_d     = j_q;
          j_d       = j_q - 8'd1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end

      // first read fetches the removed entry, then read j, write j-1
      ST_DEL: begin
        if (pend_q) begin
          if (first_q) begin
            rem_d   = ram_rdata;
            first_d = 1'b0;
          end else begin
            ram_we = 1'b1;
          end
        end
        if (j_q < cnt_q) begin
          ram_re = 1'b1;
          tgt_d  = j_q - 8'd1;
          j_d    = j_q + 8'd1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d   = cnt_q - 8'd1;
            ok_d    = 1'b1;
            state_d = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.ok            = ok_q;
          out_d.removed_value = rem_q;
          out_d.count         = cnt_q;
          out_d.is_empty      = (cnt_q == 8'd0);
          out_d.is_full       = (cnt_q == cap_eff);
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 8'd0;
      cap_q       <= DEFAULT_CAPACITY;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload and loop registers, no reset needed
  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    pos0_q <= pos0_d;
    tgt_q  <= tgt_d;
    ok_q   <= ok_d;
    val_q  <= val_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  pal_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/pal_checker.sv */
// ----------------------------------------------------------------------------
// pal_checker: port-level checks for the positional array list
// Watches both channels and the result fields; bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pal_pkg::out_t out_data_o
);

  // a result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // one beat in flight: ready falls right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.count == 8'd0)))
    else $error("empty flag disagrees with count");

  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.removed_value == 32'sd0)
    else $error("rejected beat carries a removed value");

  a_full_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_full |-> !out_data_o.is_empty)
    else $error("list reported both full and empty");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
